FILE: rtl/core/sm4_pkg.sv
// sm4_pkg: shared types, constants and functions for the sm4 block cipher core
// s-box, fk/ck parameters, linear transforms, controller states and command struct
// no dependencies

package sm4_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0]  t_idx;

    localparam int unsigned ROUNDS = 32;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam t_word FK0 = 32'ha3b1bac6;
    localparam t_word FK1 = 32'h56aa3350;
    localparam t_word FK2 = 32'h677d9197;
    localparam t_word FK3 = 32'hb27022dc;

    localparam t_idx LAST_IDX = 5'(ROUNDS - 1);

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_PREFETCH,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_block;
        logic load_key;
        logic key_step;
        logic round_step;
        logic load_out;
        t_idx step_idx;
        t_idx rd_addr;
    } t_cmd;

    function automatic t_word sub_word(input t_word a);
        sub_word = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word round_t(input t_word x);
        t_word b;
        b = sub_word(x);
        round_t = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic t_word key_t(input t_word x);
        t_word b;
        b = sub_word(x);
        key_t = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // ck byte j of word i is (4i + j) * 7 mod 256, msb first
    function automatic t_word ck_word(input t_idx i);
        t_word      w;
        logic [9:0] p;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            p = {i, 2'(j)} * 10'd7;
            w = {w[23:0], p[7:0]};
        end
        ck_word = w;
    endfunction

endpackage

FILE: rtl/core/sm4_ctrl.sv
// sm4_ctrl: controller state machine for the sm4 core
// sequences key expansion, round key prefetch, rounds and result handoff
// depends on sm4_pkg

module sm4_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sm4_pkg::t_cmd   o_cmd
);

    sm4_pkg::t_state r_state, n_state;
    sm4_pkg::t_idx   r_cnt, n_cnt;
    logic            r_dec, n_dec;
    logic            r_keys_ready, n_keys_ready;
    logic            r_out_valid, n_out_valid;
    sm4_pkg::t_idx   w_addr_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sm4_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_dec        <= sm4_pkg::OP_ENCRYPT;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_dec        <= n_dec;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_dec        = r_dec;
        n_keys_ready = r_keys_ready;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.step_idx = r_cnt;

        // round key read one step ahead of its use
        w_addr_base = (r_state == sm4_pkg::ST_ROUND) ? r_cnt + 5'd1 : r_cnt;
        o_cmd.rd_addr = (r_dec == sm4_pkg::OP_DECRYPT) ? ~w_addr_base : w_addr_base;

        unique case (r_state)
            sm4_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_block = 1'b1;
                    o_cmd.load_key   = !r_keys_ready;
                    n_dec            = i_in_op;
                    n_cnt            = '0;
                    n_state          = r_keys_ready ? sm4_pkg::ST_PREFETCH
                                                    : sm4_pkg::ST_KEXP;
                end
            end
            sm4_pkg::ST_KEXP: begin
                o_cmd.key_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == sm4_pkg::LAST_IDX) begin
                    n_keys_ready = 1'b1;
                    n_state      = sm4_pkg::ST_PREFETCH;
                end
            end
            sm4_pkg::ST_PREFETCH: begin
                n_state = sm4_pkg::ST_ROUND;
            end
            sm4_pkg::ST_ROUND: begin
                o_cmd.round_step = 1'b1;
                n_cnt            = r_cnt + 5'd1;
                if (r_cnt == sm4_pkg::LAST_IDX) begin
                    n_state = sm4_pkg::ST_DONE;
                end
            end
            sm4_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = sm4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sm4_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_keys_ready = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/sm4_dp.sv
// sm4_dp: datapath of the sm4 core
// key registers, key schedule, round key memory, round state and result register
// depends on sm4_pkg

module sm4_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [63:0]     i_cfg_data,
    input  logic [127:0]    i_block,
    input  sm4_pkg::t_cmd   i_cmd,
    output logic [127:0]    o_result
);

    logic [63:0]     r_key_high;
    logic [63:0]     r_key_low;
    sm4_pkg::t_word  r_k [4];
    sm4_pkg::t_word  r_x [4];
    sm4_pkg::t_word  r_rk_mem [32];
    sm4_pkg::t_word  r_rk;
    logic [127:0]    r_result;
    sm4_pkg::t_word  w_nk;
    sm4_pkg::t_word  w_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sm4_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                sm4_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:               r_key_low  <= r_key_low;
            endcase
        end
    end

    assign w_nk = r_k[0] ^ sm4_pkg::key_t(r_k[1] ^ r_k[2] ^ r_k[3]
                                          ^ sm4_pkg::ck_word(i_cmd.step_idx));
    assign w_nx = r_x[0] ^ sm4_pkg::round_t(r_x[1] ^ r_x[2] ^ r_x[3] ^ r_rk);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_k[0] <= r_key_high[63:32] ^ sm4_pkg::FK0;
            r_k[1] <= r_key_high[31:0]  ^ sm4_pkg::FK1;
            r_k[2] <= r_key_low[63:32]  ^ sm4_pkg::FK2;
            r_k[3] <= r_key_low[31:0]   ^ sm4_pkg::FK3;
        end else if (i_cmd.key_step) begin
            r_k[0] <= r_k[1];
            r_k[1] <= r_k[2];
            r_k[2] <= r_k[3];
            r_k[3] <= w_nk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_step) begin
            r_rk_mem[i_cmd.step_idx] <= w_nk;
        end
        r_rk <= r_rk_mem[i_cmd.rd_addr];
    end

    // block_high in the low half, x0 in its upper word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_block) begin
            r_x[0] <= i_block[63:32];
            r_x[1] <= i_block[31:0];
            r_x[2] <= i_block[127:96];
            r_x[3] <= i_block[95:64];
        end else if (i_cmd.round_step) begin
            r_x[0] <= r_x[1];
            r_x[1] <= r_x[2];
            r_x[2] <= r_x[3];
            r_x[3] <= w_nx;
        end
    end

    // reverse transform: result_high = x3:x2, result_low = x1:x0
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result <= {r_x[1], r_x[0], r_x[3], r_x[2]};
        end
    end

    assign o_result = r_result;

endmodule

FILE: rtl/core/sm4_block_cipher_core.sv
// sm4_block_cipher_core: top level of the sm4 ecb encrypt/decrypt core
// joins sm4_ctrl and sm4_dp; depends on sm4_pkg
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tuser: opcode; tdata: block_high, block_low
// m_axis    out        tdata: result_high, result_low
// cfg       in         addr 0 key_high, addr 1 key_low, 64-bit data
//
// after acceptance an item goes through one round key prefetch, 32 rounds
// of one round per clock, and a handoff to the output register that waits
// while it holds an untaken result; no new item is taken before the handoff
// after a key write the next item first runs the key schedule
// the round key memory has one read port, which sets the one round per clock rate
// a result waits in the output register while the next item is accepted and worked
// synchronous active-low reset clears control and key registers

module sm4_block_cipher_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [63:0]     i_cfg_data,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [127:0]    s_axis_tdata,   // block_high, block_low
    input  logic            s_axis_tuser,   // opcode
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [127:0]    m_axis_tdata    // result_high, result_low
);

    sm4_pkg::t_cmd w_cmd;

    sm4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sm4_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_block    (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_result   (m_axis_tdata)
    );

endmodule
